// ----- hw/rtl/ftwm_pkg.sv -----
// shared constants, codes and word types of the frame timing window monitor
`timescale 1ns / 1ps
package ftwm_pkg;

    localparam int WINDOW_DEPTH = 128;
    localparam int ADDR_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    localparam int IN_W   = 40;
    localparam int DUR_W  = 39;
    localparam int SUM_W  = 40;
    localparam int CTR_W  = 32;
    localparam int PCT_W  = 7;
    localparam int BIT_W  = $clog2(SUM_W);
    localparam int IDX_W  = 1;

    // percentile rank: ceil(x / 100) through a reciprocal multiply
    localparam int NUM_W    = PCT_W + CNT_W;
    localparam int RECIP_W  = 18;
    localparam int RECIP_SH = 24;
    localparam logic [RECIP_W-1:0] RECIP = 18'd167773;
    localparam logic [NUM_W-1:0] ROUND_UP = NUM_W'(99);
    localparam int PROD_W = NUM_W + 1 + RECIP_W;
    localparam int Q_W    = PROD_W - RECIP_SH;

    localparam logic [1:0] MODE_OBSERVE  = 2'd0;
    localparam logic [1:0] MODE_SNAPSHOT = 2'd1;
    localparam logic [1:0] MODE_CLEAR    = 2'd2;

    localparam logic [IDX_W-1:0] CFG_HITCH_FLOOR = 1'b0;
    localparam logic [IDX_W-1:0] CFG_PERCENTILE  = 1'b1;

    localparam logic [DUR_W-1:0] FLOOR_RESET = 39'd50000000;
    localparam logic [PCT_W-1:0] PCT_RESET   = 7'd95;

    typedef enum logic [1:0] {
        CMD_OBSERVE  = 2'd0,
        CMD_SNAPSHOT = 2'd1,
        CMD_CLEAR    = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [DUR_W-1:0] build;
        logic [DUR_W-1:0] present;
        logic [SUM_W-1:0] total;
        logic             hitch;
        logic             fail;
    } cmd_t;

    typedef struct packed {
        logic [CTR_W-1:0] frame_count;
        logic [CTR_W-1:0] hitch_count;
        logic [CTR_W-1:0] failure_count;
        logic [DUR_W-1:0] build_pct_ns;
        logic [DUR_W-1:0] present_pct_ns;
        logic [SUM_W-1:0] total_pct_ns;
        logic [SUM_W-1:0] total_max_ns;
    } res_t;

endpackage

// ----- hw/rtl/frame_timing_window_monitor_top.sv -----
// top level of the frame timing window monitor: config registers and result register
`timescale 1ns / 1ps
// Frame timing window monitor. Observe words (mode 0) are checked and
// classified in the front end and then written into the window memories,
// so a stream of observes runs at one word per cycle while the back end is
// idle. A clear word (mode 2) is also handled without leaving the idle
// state. A snapshot word (mode 1) walks the windows bit by bit to find the
// percentile: a multiply step and a divide step work out the rank, then
// 40 passes go over the n filled entries at one memory read per cycle,
// each window memory having a single read port; an empty window skips
// straight to the result. A two-word command queue between the front and
// back ends takes up to two more words while a snapshot is being worked;
// full rises once it holds two. Rejected observes and mode 3 words are
// taken and dropped. The snapshot word sits in an output register until
// popped. Window memories are not cleared; only filled entries are ever
// scanned. Configuration writes are registered; the user must make them
// only while the block is idle, as the block itself does not enforce it.
module frame_timing_window_monitor_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    // config write port
    input  logic                         cfg_write,
    input  logic [ftwm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ftwm_pkg::DUR_W-1:0]   cfg_data,
    // input word
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   mode,
    input  logic [ftwm_pkg::IN_W-1:0]    build_ns,
    input  logic [ftwm_pkg::IN_W-1:0]    present_ns,
    input  logic [ftwm_pkg::IN_W-1:0]    target_interval_ns,
    input  logic                         present_ok,
    // result word
    output logic                         empty,
    input  logic                         pop,
    output logic [ftwm_pkg::CTR_W-1:0]   frame_count,
    output logic [ftwm_pkg::CTR_W-1:0]   hitch_count,
    output logic [ftwm_pkg::CTR_W-1:0]   failure_count,
    output logic [ftwm_pkg::DUR_W-1:0]   build_pct_ns,
    output logic [ftwm_pkg::DUR_W-1:0]   present_pct_ns,
    output logic [ftwm_pkg::SUM_W-1:0]   total_pct_ns,
    output logic [ftwm_pkg::SUM_W-1:0]   total_max_ns
);

    logic [ftwm_pkg::DUR_W-1:0] floor_reg, floor_next;
    logic [ftwm_pkg::PCT_W-1:0] pct_reg, pct_next;

    // output register
    logic                       out_vld_reg, out_vld_next;
    ftwm_pkg::res_t             out_reg;

    logic                       cmd_valid;
    ftwm_pkg::cmd_t             cmd;
    logic                       cmd_pop;
    logic                       res_valid;
    ftwm_pkg::res_t             res;
    logic                       res_take;

    // config registers
    always_comb
    begin
        floor_next = floor_reg;
        pct_next   = pct_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                ftwm_pkg::CFG_HITCH_FLOOR: floor_next = cfg_data;
                ftwm_pkg::CFG_PERCENTILE:  pct_next   = cfg_data[ftwm_pkg::PCT_W-1:0];
                default:                   floor_next = floor_reg;
            endcase
        end
    end

    ftwm_front u_front
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .mode               (mode),
        .build_ns           (build_ns),
        .present_ns         (present_ns),
        .target_interval_ns (target_interval_ns),
        .present_ok         (present_ok),
        .hitch_floor        (floor_reg),
        .cmd_valid          (cmd_valid),
        .cmd                (cmd),
        .cmd_pop            (cmd_pop)
    );

    ftwm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .percentile (pct_reg),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take)
    );

    // load the result word when the register is free or being popped
    assign res_take = res_valid & (~out_vld_reg | pop);

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (res_take)
        begin
            out_vld_next = 1'b1;
        end
        else if (pop)
        begin
            out_vld_next = 1'b0;
        end
    end

    assign empty          = ~out_vld_reg;
    assign frame_count    = out_reg.frame_count;
    assign hitch_count    = out_reg.hitch_count;
    assign failure_count  = out_reg.failure_count;
    assign build_pct_ns   = out_reg.build_pct_ns;
    assign present_pct_ns = out_reg.present_pct_ns;
    assign total_pct_ns   = out_reg.total_pct_ns;
    assign total_max_ns   = out_reg.total_max_ns;

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg   <= ftwm_pkg::FLOOR_RESET;
            pct_reg     <= ftwm_pkg::PCT_RESET;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            floor_reg   <= floor_next;
            pct_reg     <= pct_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

// ----- hw/rtl/ftwm_front.sv -----
// front end: checks and classifies input words into a two-entry command queue
`timescale 1ns / 1ps
module ftwm_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  mode,
    input  logic [ftwm_pkg::IN_W-1:0]   build_ns,
    input  logic [ftwm_pkg::IN_W-1:0]   present_ns,
    input  logic [ftwm_pkg::IN_W-1:0]   target_interval_ns,
    input  logic                        present_ok,
    input  logic [ftwm_pkg::DUR_W-1:0]  hitch_floor,
    output logic                        cmd_valid,
    output ftwm_pkg::cmd_t              cmd,
    input  logic                        cmd_pop
);

    ftwm_pkg::cmd_t            q_reg [2];
    logic                      wr_ptr_reg, wr_ptr_next;
    logic                      rd_ptr_reg, rd_ptr_next;
    logic [1:0]                cnt_reg, cnt_next;

    ftwm_pkg::cmd_t            cls;
    logic                      keep;
    logic                      reject;
    logic [ftwm_pkg::SUM_W-1:0] twice;
    logic [ftwm_pkg::SUM_W-1:0] floor_ext;
    logic [ftwm_pkg::SUM_W-1:0] thr;
    logic                      do_push;

    always_comb
    begin
        reject    = build_ns[ftwm_pkg::IN_W-1] | present_ns[ftwm_pkg::IN_W-1]
                  | target_interval_ns[ftwm_pkg::IN_W-1]
                  | (target_interval_ns == '0);
        twice     = {target_interval_ns[ftwm_pkg::IN_W-2:0], 1'b0};
        floor_ext = {1'b0, hitch_floor};
        thr       = (floor_ext > twice) ? floor_ext : twice;

        cls.build   = build_ns[ftwm_pkg::DUR_W-1:0];
        cls.present = present_ns[ftwm_pkg::DUR_W-1:0];
        cls.total   = {1'b0, build_ns[ftwm_pkg::DUR_W-1:0]}
                    + {1'b0, present_ns[ftwm_pkg::DUR_W-1:0]};
        cls.hitch   = (cls.total > thr);
        cls.fail    = ~present_ok;
        cls.kind    = ftwm_pkg::CMD_OBSERVE;
        keep        = 1'b0;
        case (mode)
            ftwm_pkg::MODE_OBSERVE:
            begin
                cls.kind = ftwm_pkg::CMD_OBSERVE;
                keep     = ~reject;
            end
            ftwm_pkg::MODE_SNAPSHOT:
            begin
                cls.kind = ftwm_pkg::CMD_SNAPSHOT;
                keep     = 1'b1;
            end
            ftwm_pkg::MODE_CLEAR:
            begin
                cls.kind = ftwm_pkg::CMD_CLEAR;
                keep     = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push & ~full & keep;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ (cmd_pop & cmd_valid);
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, cmd_pop & cmd_valid};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("command queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("pop from empty command queue");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !cmd_pop) |=> full)
        else $error("full queue drained without pop");

endmodule

// ----- hw/rtl/ftwm_back.sv -----
// back end: windows, counters and the bit-by-bit percentile selection
`timescale 1ns / 1ps
module ftwm_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  ftwm_pkg::cmd_t              cmd,
    output logic                        cmd_pop,
    input  logic [ftwm_pkg::PCT_W-1:0]  percentile,
    output logic                        res_valid,
    output ftwm_pkg::res_t              res,
    input  logic                        res_take
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_RANK_MUL = 7'b0000010,
        ST_RANK_DIV = 7'b0000100,
        ST_SCAN     = 7'b0001000,
        ST_DRAIN    = 7'b0010000,
        ST_DECIDE   = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    localparam int SW = ftwm_pkg::SUM_W;
    localparam int CW = ftwm_pkg::CNT_W;

    logic [ftwm_pkg::DUR_W-1:0] build_mem   [ftwm_pkg::WINDOW_DEPTH];
    logic [ftwm_pkg::DUR_W-1:0] present_mem [ftwm_pkg::WINDOW_DEPTH];
    logic [SW-1:0]              total_mem   [ftwm_pkg::WINDOW_DEPTH];
    logic [ftwm_pkg::DUR_W-1:0] rd_b_reg, rd_p_reg;
    logic [SW-1:0]              rd_t_reg;

    state_t                      state_reg, state_next;
    logic [ftwm_pkg::ADDR_W-1:0] slot_reg, slot_next;
    logic [CW-1:0]               fill_reg, fill_next;
    logic [ftwm_pkg::CTR_W-1:0]  frames_reg, frames_next;
    logic [ftwm_pkg::CTR_W-1:0]  hitches_reg, hitches_next;
    logic [ftwm_pkg::CTR_W-1:0]  fails_reg, fails_next;
    logic [ftwm_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [ftwm_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [ftwm_pkg::BIT_W-1:0]  bit_reg, bit_next;
    logic                        rd_vld_reg, rd_vld_next;
    logic [SW-1:0]               mx_reg, mx_next;
    logic [CW-1:0]               rank_reg [3];
    logic [CW-1:0]               rank_next [3];
    logic [CW-1:0]               cnt0_reg [3];
    logic [CW-1:0]               cnt0_next [3];
    logic [SW-1:0]               pfx_reg [3];
    logic [SW-1:0]               pfx_next [3];

    logic                        mem_we;
    logic [SW-1:0]               lane_data [3];
    logic [SW:0]                 mask_wide;
    logic [SW-1:0]               hi_mask;
    logic [ftwm_pkg::PROD_W-1:0] prod;
    logic [ftwm_pkg::Q_W-1:0]    q_val;
    logic [ftwm_pkg::Q_W-1:0]    q_m1;
    logic [ftwm_pkg::Q_W-1:0]    last_q;
    logic [CW-1:0]               rank_sel;

    function automatic logic [ftwm_pkg::CTR_W-1:0] bump(input logic [ftwm_pkg::CTR_W-1:0] c);
        bump = (c == '1) ? c : c + 1'b1;
    endfunction

    assign lane_data[0] = {1'b0, rd_b_reg};
    assign lane_data[1] = {1'b0, rd_p_reg};
    assign lane_data[2] = rd_t_reg;

    // bits above the one being decided must match the prefix found so far
    assign mask_wide = {(SW + 1){1'b1}} << (ftwm_pkg::BIT_W'(bit_reg) + 1'b1);
    assign hi_mask   = mask_wide[SW-1:0];

    assign prod   = ({1'b0, num_reg} + {1'b0, ftwm_pkg::ROUND_UP}) * ftwm_pkg::RECIP;
    assign q_val  = prod[ftwm_pkg::PROD_W-1:ftwm_pkg::RECIP_SH];
    assign q_m1   = (q_val == '0) ? q_val : q_val - 1'b1;
    assign last_q = ftwm_pkg::Q_W'(fill_reg - 1'b1);
    assign rank_sel = (q_m1 > last_q) ? (fill_reg - 1'b1) : q_m1[CW-1:0];

    assign mem_we = (state_reg == ST_IDLE) && cmd_valid && (cmd.kind == ftwm_pkg::CMD_OBSERVE);

    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        fill_next    = fill_reg;
        frames_next  = frames_reg;
        hitches_next = hitches_reg;
        fails_next   = fails_reg;
        num_next     = num_reg;
        addr_next    = addr_reg;
        bit_next     = bit_reg;
        rd_vld_next  = 1'b0;
        mx_next      = mx_reg;
        cmd_pop      = 1'b0;
        res_valid    = 1'b0;
        for (int l = 0; l < 3; l++)
        begin
            rank_next[l] = rank_reg[l];
            cnt0_next[l] = cnt0_reg[l];
            pfx_next[l]  = pfx_reg[l];
        end

        // count entries under the prefix whose current bit is zero
        if (rd_vld_reg)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if ((((lane_data[l] ^ pfx_reg[l]) & hi_mask) == '0) && !lane_data[l][bit_reg])
                begin
                    cnt0_next[l] = cnt0_reg[l] + 1'b1;
                end
            end
            if ((bit_reg == ftwm_pkg::BIT_W'(SW - 1)) && (lane_data[2] > mx_reg))
            begin
                mx_next = lane_data[2];
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        ftwm_pkg::CMD_OBSERVE:
                        begin
                            slot_next = (slot_reg == ftwm_pkg::ADDR_W'(ftwm_pkg::WINDOW_DEPTH - 1))
                                      ? '0 : slot_reg + 1'b1;
                            if (fill_reg != CW'(ftwm_pkg::WINDOW_DEPTH))
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                            frames_next = bump(frames_reg);
                            if (cmd.hitch)
                            begin
                                hitches_next = bump(hitches_reg);
                            end
                            if (cmd.fail)
                            begin
                                fails_next = bump(fails_reg);
                            end
                        end
                        ftwm_pkg::CMD_SNAPSHOT:
                        begin
                            mx_next   = '0;
                            addr_next = '0;
                            bit_next  = ftwm_pkg::BIT_W'(SW - 1);
                            for (int l = 0; l < 3; l++)
                            begin
                                pfx_next[l]  = '0;
                                cnt0_next[l] = '0;
                            end
                            state_next = (fill_reg == '0) ? ST_DONE : ST_RANK_MUL;
                        end
                        ftwm_pkg::CMD_CLEAR:
                        begin
                            slot_next = '0;
                            fill_next = '0;
                        end
                        default:
                        begin
                            slot_next = slot_reg;
                        end
                    endcase
                end
            end
            ST_RANK_MUL:
            begin
                num_next   = ftwm_pkg::NUM_W'(percentile) * ftwm_pkg::NUM_W'(fill_reg);
                state_next = ST_RANK_DIV;
            end
            ST_RANK_DIV:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rank_next[l] = rank_sel;
                end
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                rd_vld_next = 1'b1;
                addr_next   = addr_reg + 1'b1;
                if (CW'(addr_reg) + 1'b1 == fill_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    cnt0_next[l] = '0;
                    if (rank_reg[l] >= cnt0_reg[l])
                    begin
                        rank_next[l]         = rank_reg[l] - cnt0_reg[l];
                        pfx_next[l][bit_reg] = 1'b1;
                    end
                end
                addr_next = '0;
                if (bit_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.frame_count    = frames_reg;
        res.hitch_count    = hitches_reg;
        res.failure_count  = fails_reg;
        res.build_pct_ns   = pfx_reg[0][ftwm_pkg::DUR_W-1:0];
        res.present_pct_ns = pfx_reg[1][ftwm_pkg::DUR_W-1:0];
        res.total_pct_ns   = pfx_reg[2];
        res.total_max_ns   = mx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            build_mem[slot_reg]   <= cmd.build;
            present_mem[slot_reg] <= cmd.present;
            total_mem[slot_reg]   <= cmd.total;
        end
        rd_b_reg <= build_mem[addr_reg];
        rd_p_reg <= present_mem[addr_reg];
        rd_t_reg <= total_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        mx_reg  <= mx_next;
        for (int l = 0; l < 3; l++)
        begin
            rank_reg[l] <= rank_next[l];
            cnt0_reg[l] <= cnt0_next[l];
            pfx_reg[l]  <= pfx_next[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            fill_reg    <= '0;
            frames_reg  <= '0;
            hitches_reg <= '0;
            fails_reg   <= '0;
            addr_reg    <= '0;
            bit_reg     <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            frames_reg  <= frames_next;
            hitches_reg <= hitches_next;
            fails_reg   <= fails_next;
            addr_reg    <= addr_next;
            bit_reg     <= bit_next;
            rd_vld_reg  <= rd_vld_next;
        end
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(ftwm_pkg::WINDOW_DEPTH))
        else $error("fill level above window depth");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == ST_IDLE))
        else $error("command taken while busy");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CW'(addr_reg) < fill_reg))
        else $error("scan address beyond fill level");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_take) |=> (res_valid && $stable(res)))
        else $error("result dropped or changed while waiting");

endmodule

// ----- dv/tb_frame_timing_window_monitor_top.sv -----
// self-checking testbench for the frame timing window monitor top level
`timescale 1ns / 1ps
module tb_frame_timing_window_monitor_top;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [63:0] MAX39 = 64'h7F_FFFF_FFFF;
    localparam int N_RANDOM = 1200;
    localparam int N_DIRECTED = 22;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [ftwm_pkg::IDX_W-1:0]    cfg_index;
    logic [ftwm_pkg::DUR_W-1:0]    cfg_data;
    logic                          push;
    logic                          full;
    logic [1:0]                    mode;
    logic [ftwm_pkg::IN_W-1:0]     build_ns;
    logic [ftwm_pkg::IN_W-1:0]     present_ns;
    logic [ftwm_pkg::IN_W-1:0]     target_interval_ns;
    logic                          present_ok;
    logic                          empty;
    logic                          pop;
    ftwm_pkg::res_t                snap_out;

    frame_timing_window_monitor_top dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .push               (push),
        .full               (full),
        .mode               (mode),
        .build_ns           (build_ns),
        .present_ns         (present_ns),
        .target_interval_ns (target_interval_ns),
        .present_ok         (present_ok),
        .empty              (empty),
        .pop                (pop),
        .frame_count        (snap_out.frame_count),
        .hitch_count        (snap_out.hitch_count),
        .failure_count      (snap_out.failure_count),
        .build_pct_ns       (snap_out.build_pct_ns),
        .present_pct_ns     (snap_out.present_pct_ns),
        .total_pct_ns       (snap_out.total_pct_ns),
        .total_max_ns       (snap_out.total_max_ns)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // predictor state: shadow copy of windows, counters and registers
    // ---------------------------------------------------------------
    logic [ftwm_pkg::DUR_W-1:0] shadow_build [ftwm_pkg::WINDOW_DEPTH];
    logic [ftwm_pkg::DUR_W-1:0] shadow_present [ftwm_pkg::WINDOW_DEPTH];
    logic [ftwm_pkg::SUM_W-1:0] shadow_total [ftwm_pkg::WINDOW_DEPTH];
    int unsigned                slot_ptr;
    int unsigned                fill_cnt;
    logic [ftwm_pkg::CTR_W-1:0] frames_acc;
    logic [ftwm_pkg::CTR_W-1:0] hitches_acc;
    logic [ftwm_pkg::CTR_W-1:0] failures_acc;
    logic [ftwm_pkg::DUR_W-1:0] floor_reg;
    logic [ftwm_pkg::PCT_W-1:0] pct_reg;

    // snapshots still owed by the block, oldest first
    ftwm_pkg::res_t pending_snaps [$];

    int  fail_cnt;
    int  snd_idle_pct;
    int  rcv_idle_pct;
    bit  long_hold_req;

    function automatic logic [ftwm_pkg::CTR_W-1:0] sat_inc(logic [ftwm_pkg::CTR_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // percentile entry of the first fill_cnt values, rank ceil(p*n/100)-1 capped at n-1
    function automatic logic [ftwm_pkg::SUM_W-1:0] pick_percentile(
        logic [ftwm_pkg::SUM_W-1:0] vals [$]);
        longint unsigned rank;
        int unsigned     n;
        n = vals.size();
        if (n == 0)
            return '0;
        vals.sort();
        rank = (longint'(pct_reg) * n + 99) / 100;
        if (rank > 0)
            rank--;
        if (rank > n - 1)
            rank = n - 1;
        return vals[rank];
    endfunction

    // update shadow state for one accepted word; returns 1 when a snapshot is owed
    function automatic bit frame_predict(logic [1:0] m, logic [ftwm_pkg::IN_W-1:0] b,
                                         logic [ftwm_pkg::IN_W-1:0] p,
                                         logic [ftwm_pkg::IN_W-1:0] t,
                                         logic ok, output ftwm_pkg::res_t snap);
        logic [ftwm_pkg::SUM_W-1:0] bq [$];
        logic [ftwm_pkg::SUM_W-1:0] pq [$];
        logic [ftwm_pkg::SUM_W-1:0] tq [$];
        logic [ftwm_pkg::SUM_W-1:0] sum;
        logic [ftwm_pkg::IN_W:0]    thr;
        snap = '0;
        if (m == ftwm_pkg::MODE_OBSERVE)
        begin
            if (b[ftwm_pkg::IN_W-1] || p[ftwm_pkg::IN_W-1] || t[ftwm_pkg::IN_W-1] || t == '0)
                return 1'b0;
            sum = b + p;
            shadow_build[slot_ptr] = b[ftwm_pkg::DUR_W-1:0];
            shadow_present[slot_ptr] = p[ftwm_pkg::DUR_W-1:0];
            shadow_total[slot_ptr] = sum;
            slot_ptr = (slot_ptr + 1) % ftwm_pkg::WINDOW_DEPTH;
            if (fill_cnt < ftwm_pkg::WINDOW_DEPTH)
                fill_cnt++;
            frames_acc = sat_inc(frames_acc);
            thr = {t, 1'b0};
            if ({2'b00, floor_reg} > thr)
                thr = {2'b00, floor_reg};
            if ({1'b0, sum} > thr)
                hitches_acc = sat_inc(hitches_acc);
            if (!ok)
                failures_acc = sat_inc(failures_acc);
            return 1'b0;
        end
        if (m == ftwm_pkg::MODE_SNAPSHOT)
        begin
            snap.frame_count = frames_acc;
            snap.hitch_count = hitches_acc;
            snap.failure_count = failures_acc;
            for (int i = 0; i < fill_cnt; i++)
            begin
                bq.push_back(ftwm_pkg::SUM_W'(shadow_build[i]));
                pq.push_back(ftwm_pkg::SUM_W'(shadow_present[i]));
                tq.push_back(shadow_total[i]);
                if (shadow_total[i] > snap.total_max_ns)
                    snap.total_max_ns = shadow_total[i];
            end
            snap.build_pct_ns = ftwm_pkg::DUR_W'(pick_percentile(bq));
            snap.present_pct_ns = ftwm_pkg::DUR_W'(pick_percentile(pq));
            snap.total_pct_ns = pick_percentile(tq);
            return 1'b1;
        end
        if (m == ftwm_pkg::MODE_CLEAR)
        begin
            slot_ptr = 0;
            fill_cnt = 0;
        end
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // sender side helpers
    // ---------------------------------------------------------------
    // offer one word and hold it until the block takes it
    task automatic send_word(logic [1:0] m, logic [ftwm_pkg::IN_W-1:0] b,
                             logic [ftwm_pkg::IN_W-1:0] p, logic [ftwm_pkg::IN_W-1:0] t,
                             logic ok, bit typed, ftwm_pkg::res_t typed_snap);
        ftwm_pkg::res_t snap;
        bit             owed;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        mode <= m;
        build_ns <= b;
        present_ns <= p;
        target_interval_ns <= t;
        present_ok <= ok;
        do
            @(posedge clk);
        while (full);
        owed = frame_predict(m, b, p, t, ok, snap);
        // a typed row replaces the predicted word with the hand-written one
        if (owed)
            pending_snaps.push_back(typed ? typed_snap : snap);
    endtask

    // wait until every owed snapshot is out and the back end has settled
    task automatic drain_block();
        push <= 1'b0;
        @(posedge clk);
        while (pending_snaps.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_regs(logic [ftwm_pkg::DUR_W-1:0] floor_val,
                              logic [ftwm_pkg::PCT_W-1:0] pct_val);
        drain_block();
        cfg_write <= 1'b1;
        cfg_index <= ftwm_pkg::CFG_HITCH_FLOOR;
        cfg_data <= floor_val;
        @(posedge clk);
        cfg_index <= ftwm_pkg::CFG_PERCENTILE;
        cfg_data <= ftwm_pkg::DUR_W'(pct_val);
        @(posedge clk);
        cfg_write <= 1'b0;
        floor_reg = floor_val;
        pct_reg = pct_val;
    endtask

    // random non-negative duration of random bit length
    function automatic logic [ftwm_pkg::IN_W-1:0] rand_dur();
        logic [63:0] v;
        int          w;
        v = {$urandom, $urandom};
        w = $urandom_range(1, ftwm_pkg::DUR_W);
        return ftwm_pkg::IN_W'(v & ((64'd1 << w) - 1));
    endfunction

    // ---------------------------------------------------------------
    // directed table
    // ---------------------------------------------------------------
    typedef struct {
        logic [1:0]                m;
        logic [ftwm_pkg::IN_W-1:0] b;
        logic [ftwm_pkg::IN_W-1:0] p;
        logic [ftwm_pkg::IN_W-1:0] t;
        logic                      ok;
        bit                        typed;
        ftwm_pkg::res_t            snap;
    } stim_row_t;

    stim_row_t dir_rows [N_DIRECTED];

    function automatic stim_row_t mk_row(logic [1:0] m, logic [ftwm_pkg::IN_W-1:0] b,
                                         logic [ftwm_pkg::IN_W-1:0] p,
                                         logic [ftwm_pkg::IN_W-1:0] t,
                                         logic ok);
        stim_row_t r;
        r.m = m;
        r.b = b;
        r.p = p;
        r.t = t;
        r.ok = ok;
        r.typed = 1'b0;
        r.snap = '0;
        return r;
    endfunction

    initial
    begin
        // empty window right after reset: everything zero
        dir_rows[0] = mk_row(ftwm_pkg::MODE_SNAPSHOT, '0, '0, '0, 1'b1);
        dir_rows[0].typed = 1'b1;
        // largest legal durations, shortest interval, failed present
        dir_rows[1] = mk_row(ftwm_pkg::MODE_OBSERVE, ftwm_pkg::IN_W'(MAX39),
                             ftwm_pkg::IN_W'(MAX39), 40'd1, 1'b0);
        dir_rows[2] = mk_row(ftwm_pkg::MODE_SNAPSHOT, '0, '0, '0, 1'b1);
        dir_rows[2].typed = 1'b1;
        dir_rows[2].snap = '{32'd1, 32'd1, 32'd1, MAX39[ftwm_pkg::DUR_W-1:0],
                             MAX39[ftwm_pkg::DUR_W-1:0],
                             40'hFF_FFFF_FFFE, 40'hFF_FFFF_FFFE};
        // rejected samples: negative build, negative present, zero and negative interval
        dir_rows[3] = mk_row(ftwm_pkg::MODE_OBSERVE, 40'h80_0000_0000, 40'd5, 40'd10, 1'b1);
        dir_rows[4] = mk_row(ftwm_pkg::MODE_OBSERVE, 40'd5, '1, 40'd10, 1'b0);
        dir_rows[5] = mk_row(ftwm_pkg::MODE_OBSERVE, 40'd5, 40'd5, '0, 1'b0);
        dir_rows[6] = mk_row(ftwm_pkg::MODE_OBSERVE, 40'd5, 40'd5, 40'h80_0000_0000, 1'b0);
        // unused mode is dropped
        dir_rows[7] = mk_row(MODE_UNUSED, 40'd7, 40'd7, 40'd7, 1'b0);
        dir_rows[8] = mk_row(ftwm_pkg::MODE_SNAPSHOT, '0, '0, '0, 1'b1);
        dir_rows[8].typed = 1'b1;
        dir_rows[8].snap = dir_rows[2].snap;
        // zero durations, largest interval, totals around the default floor and twice the interval
        dir_rows[9] = mk_row(ftwm_pkg::MODE_OBSERVE, '0, '0, ftwm_pkg::IN_W'(MAX39), 1'b1);
        dir_rows[10] = mk_row(ftwm_pkg::MODE_OBSERVE, 40'd25000000, 40'd25000000, 40'd1000,
                              1'b1);
        dir_rows[11] = mk_row(ftwm_pkg::MODE_OBSERVE, 40'd25000000, 40'd25000001, 40'd1000,
                              1'b1);
        dir_rows[12] = mk_row(ftwm_pkg::MODE_OBSERVE, 40'd30000000, 40'd30000000,
                              40'd30000000, 1'b0);
        dir_rows[13] = mk_row(ftwm_pkg::MODE_OBSERVE, 40'd30000000, 40'd30000001,
                              40'd30000000, 1'b1);
        dir_rows[14] = mk_row(ftwm_pkg::MODE_SNAPSHOT, '0, '0, '0, 1'b0);
        // clear keeps counters, empties the window
        dir_rows[15] = mk_row(ftwm_pkg::MODE_CLEAR, 40'd1, 40'd1, 40'd1, 1'b1);
        dir_rows[16] = mk_row(ftwm_pkg::MODE_SNAPSHOT, '0, '0, '0, 1'b1);
        dir_rows[17] = mk_row(ftwm_pkg::MODE_OBSERVE, 40'd3, 40'd9, 40'd2, 1'b1);
        dir_rows[18] = mk_row(ftwm_pkg::MODE_OBSERVE, 40'd1, 40'd4, 40'd2, 1'b1);
        dir_rows[19] = mk_row(ftwm_pkg::MODE_OBSERVE, 40'd2, 40'd1, 40'd2, 1'b0);
        dir_rows[20] = mk_row(ftwm_pkg::MODE_SNAPSHOT, '0, '0, '0, 1'b1);
        dir_rows[21] = mk_row(ftwm_pkg::MODE_CLEAR, '0, '0, '0, 1'b0);
    end

    // ---------------------------------------------------------------
    // sender: directed table, then random phases
    // ---------------------------------------------------------------
    initial
    begin
        logic [ftwm_pkg::DUR_W-1:0] floor_set [6];
        logic [ftwm_pkg::PCT_W-1:0] pct_set [6];
        logic [1:0]                 m;
        logic [ftwm_pkg::IN_W-1:0]  b;
        logic [ftwm_pkg::IN_W-1:0]  p;
        logic [ftwm_pkg::IN_W-1:0]  t;
        int                         r;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        push = 1'b0;
        mode = ftwm_pkg::MODE_OBSERVE;
        build_ns = '0;
        present_ns = '0;
        target_interval_ns = '0;
        present_ok = 1'b0;
        pop = 1'b0;
        fail_cnt = 0;
        slot_ptr = 0;
        fill_cnt = 0;
        frames_acc = '0;
        hitches_acc = '0;
        failures_acc = '0;
        floor_reg = ftwm_pkg::FLOOR_RESET;
        pct_reg = ftwm_pkg::PCT_RESET;
        snd_idle_pct = 28;
        rcv_idle_pct = 61;
        long_hold_req = 1'b0;
        for (int i = 0; i < ftwm_pkg::WINDOW_DEPTH; i++)
        begin
            shadow_build[i] = '0;
            shadow_present[i] = '0;
            shadow_total[i] = '0;
        end

        // register settings per phase: extremes, out-of-range percentiles, defaults
        floor_set = '{39'd0, MAX39[ftwm_pkg::DUR_W-1:0], 39'd40000, 39'd50000000,
                      39'd25000000, ftwm_pkg::FLOOR_RESET};
        pct_set = '{7'd1, 7'd100, 7'd50, 7'd0, 7'd127, ftwm_pkg::PCT_RESET};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs on reset register values
        for (int i = 0; i < N_DIRECTED; i++)
            send_word(dir_rows[i].m, dir_rows[i].b, dir_rows[i].p, dir_rows[i].t,
                      dir_rows[i].ok, dir_rows[i].typed, dir_rows[i].snap);

        for (int k = 0; k < N_RANDOM; k++)
        begin
            // idling phases: sender light / receiver heavy, swapped, then none
            if (k == 400)
            begin
                snd_idle_pct = 61;
                rcv_idle_pct = 28;
            end
            if (k == 800)
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            // new register setting every 200 words, with the block drained first
            if (k % 200 == 0)
                write_regs(floor_set[k / 200], pct_set[k / 200]);

            // receiver stops for a long stretch while cheap snapshots pile up
            if (k == 300)
            begin
                long_hold_req = 1'b1;
                send_word(ftwm_pkg::MODE_CLEAR, '0, '0, '0, 1'b1, 1'b0, '0);
                for (int j = 0; j < 8; j++)
                    send_word(ftwm_pkg::MODE_SNAPSHOT, rand_dur(), rand_dur(), rand_dur(),
                              1'b1, 1'b0, '0);
            end

            r = $urandom_range(999);
            m = ftwm_pkg::MODE_OBSERVE;
            b = rand_dur();
            p = rand_dur();
            t = rand_dur();
            if (t == '0)
                t = 40'd1;
            // keep a share of totals near the hitch threshold
            if ($urandom_range(3) == 0)
            begin
                b = ftwm_pkg::IN_W'($urandom_range(40000000));
                p = ftwm_pkg::IN_W'($urandom_range(40000000));
                t = ftwm_pkg::IN_W'($urandom_range(1, 40000000));
            end
            if (r < 40)
                m = ftwm_pkg::MODE_SNAPSHOT;
            else if (r < 50)
                m = ftwm_pkg::MODE_CLEAR;
            else if (r < 65)
                m = MODE_UNUSED;
            else if (r < 80)
                b[ftwm_pkg::IN_W-1] = 1'b1;
            else if (r < 95)
                p[ftwm_pkg::IN_W-1] = 1'b1;
            else if (r < 105)
                t[ftwm_pkg::IN_W-1] = 1'b1;
            else if (r < 110)
                t = '0;
            send_word(m, b, p, t, 1'(($urandom_range(3) != 0)), 1'b0, '0);
        end

        // final drain, then verdict
        drain_block();
        repeat (50) @(posedge clk);
        if (fail_cnt == 0 && pending_snaps.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // receiver: random pop, one long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && hold_left == 0)
            begin
                long_hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // result checker: compare each popped word with the oldest owed snapshot
    // ---------------------------------------------------------------
    task automatic cmp_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_cnt++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, fname, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        ftwm_pkg::res_t exp_snap;
        if (rst_n && pop && !empty)
        begin
            if (pending_snaps.size() == 0)
            begin
                fail_cnt++;
                $display("%0t unexpected result word: expected none actual frame_count %0d",
                         $time, snap_out.frame_count);
            end
            else
            begin
                exp_snap = pending_snaps.pop_front();
                cmp_field("frame_count", exp_snap.frame_count, snap_out.frame_count);
                cmp_field("hitch_count", exp_snap.hitch_count, snap_out.hitch_count);
                cmp_field("failure_count", exp_snap.failure_count, snap_out.failure_count);
                cmp_field("build_pct_ns", exp_snap.build_pct_ns, snap_out.build_pct_ns);
                cmp_field("present_pct_ns", exp_snap.present_pct_ns, snap_out.present_pct_ns);
                cmp_field("total_pct_ns", exp_snap.total_pct_ns, snap_out.total_pct_ns);
                cmp_field("total_max_ns", exp_snap.total_max_ns, snap_out.total_max_ns);
            end
        end
    end

    // run limit
    initial
    begin
        #500ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ftwm_pkg.sv
hw/rtl/ftwm_front.sv
hw/rtl/ftwm_back.sv
hw/rtl/frame_timing_window_monitor_top.sv
dv/tb_frame_timing_window_monitor_top.sv
